// File: sv/gbnrx_pkg.sv
package gbnrx_pkg;

    localparam int unsigned MAX_PAYLOAD     = 2048;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned SEQ_W  = 32;
    localparam int unsigned PLEN_W = 12;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned CFG_W  = 32;

    localparam logic [WORD_W-1:0] SUM_GOOD  = 16'hFFFF;
    localparam logic [WORD_W-1:0] LEN_RESET = 16'd2068;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_ADDR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PSEUDO_LEN = 2'd2;

    // one finished packet as handed from the front to the back
    typedef struct packed {
        logic              sum_good;
        logic [SEQ_W-1:0]  seq;
        logic              end_flag;
        logic [PLEN_W-1:0] plen;
    } t_pkt_desc;

    // ones'-complement add with end-around carry
    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

    // pseudo-header sum: five words added wide, then folded twice
    function automatic logic [WORD_W-1:0] seed_sum(input logic [CFG_W-1:0]  src,
                                                   input logic [CFG_W-1:0]  dst,
                                                   input logic [WORD_W-1:0] len);
        logic [WORD_W+2:0] s;
        logic [WORD_W:0]   f;
        s = {3'b0, src[15:0]} + {3'b0, src[31:16]} + {3'b0, dst[15:0]}
          + {3'b0, dst[31:16]} + {3'b0, len};
        f = {1'b0, s[WORD_W-1:0]} + {{(WORD_W-2){1'b0}}, s[WORD_W+2:WORD_W]};
        return f[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, f[WORD_W]};
    endfunction

endpackage

// File: sv/gbnrx_if.sv
interface gbnrx_in_if import gbnrx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic              last_word;
    logic [SEQ_W-1:0]  seq_number;
    logic              end_flag;
    logic [PLEN_W-1:0] payload_length;

    modport source (output valid, data_word, last_word, seq_number, end_flag,
                    payload_length, input ready);
    modport sink   (input valid, data_word, last_word, seq_number, end_flag,
                    payload_length, output ready);
endinterface

interface gbnrx_out_if import gbnrx_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] ack_number;
    logic             end_ack;
    logic             accepted;
    logic [CNT_W-1:0] total_bytes;

    modport source (output valid, ack_number, end_ack, accepted, total_bytes,
                    input ready);
    modport sink   (input valid, ack_number, end_ack, accepted, total_bytes,
                    output ready);
endinterface

// File: sv/gbnrx_front.sv
module gbnrx_front import gbnrx_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    gbnrx_in_if.sink             i_pkt,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_pkt_desc            o_desc
);

    logic [CFG_W-1:0]  r_src, n_src;
    logic [CFG_W-1:0]  r_dst, n_dst;
    logic [WORD_W-1:0] r_len, n_len;
    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_sum;
    logic              r_mid;
    logic [WORD_W-1:0] cur_sum;
    logic [WORD_W-1:0] new_sum;
    logic              accept;

    always_comb begin
        n_src = r_src;
        n_dst = r_dst;
        n_len = r_len;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_ADDR:   n_src = i_cfg_data;
                CFG_DST_ADDR:   n_dst = i_cfg_data;
                CFG_PSEUDO_LEN: n_len = i_cfg_data[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_pkt.ready = !i_q_full;
    assign accept      = i_pkt.valid && !i_q_full;

    // a packet in progress keeps its own sum, a new one starts from the seed
    assign cur_sum = r_mid ? r_sum : r_seed;
    assign new_sum = oc_add(cur_sum, i_pkt.data_word);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src  <= '0;
            r_dst  <= '0;
            r_len  <= LEN_RESET;
            r_seed <= seed_sum('0, '0, LEN_RESET);
            r_mid  <= 1'b0;
        end else begin
            r_src  <= n_src;
            r_dst  <= n_dst;
            r_len  <= n_len;
            r_seed <= seed_sum(n_src, n_dst, n_len);
            if (accept) begin
                r_mid <= !i_pkt.last_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum <= new_sum;
        end
    end

    assign o_push          = accept && i_pkt.last_word;
    assign o_desc.sum_good = (new_sum == SUM_GOOD);
    assign o_desc.seq      = i_pkt.seq_number;
    assign o_desc.end_flag = i_pkt.end_flag;
    assign o_desc.plen     = ({{(32-PLEN_W){1'b0}}, i_pkt.payload_length} > MAX_PAYLOAD)
                           ? PLEN_W'(MAX_PAYLOAD) : i_pkt.payload_length;

endmodule

// File: sv/gbnrx_queue.sv
module gbnrx_queue import gbnrx_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_pkt_desc i_desc,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_pkt_desc o_desc
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_pkt_desc         r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// File: sv/gbnrx_back.sv
module gbnrx_back import gbnrx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_pkt_desc i_desc,
    output logic      o_pop,
    gbnrx_out_if.source o_ack
);

    logic [SEQ_W-1:0] r_exp_seq, n_exp_seq;
    logic [CNT_W-1:0] r_total, n_total;
    logic             r_out_valid;
    logic [SEQ_W-1:0] r_ack_number, n_ack_number;
    logic             r_end_ack, n_end_ack;
    logic             r_accepted, n_accepted;
    logic [CNT_W-1:0] r_total_bytes, n_total_bytes;
    logic             produce;

    // a waiting item is taken whenever the output register is free or emptying
    assign o_pop = i_q_valid && (!r_out_valid || o_ack.ready);

    always_comb begin
        n_exp_seq     = r_exp_seq;
        n_total       = r_total;
        produce       = 1'b0;
        n_ack_number  = '0;
        n_end_ack     = 1'b0;
        n_accepted    = 1'b0;
        n_total_bytes = r_total;
        if (i_desc.end_flag) begin
            produce   = 1'b1;
            n_end_ack = 1'b1;
            n_exp_seq = SEQ_W'(1);
            n_total   = '0;
        end else if (i_desc.seq != r_exp_seq) begin
            produce      = 1'b1;
            n_ack_number = r_exp_seq - 1'b1;
        end else if (i_desc.sum_good) begin
            produce       = 1'b1;
            n_ack_number  = r_exp_seq;
            n_accepted    = 1'b1;
            n_exp_seq     = r_exp_seq + 1'b1;
            n_total       = r_total + {{(CNT_W-PLEN_W){1'b0}}, i_desc.plen};
            n_total_bytes = n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_seq   <= SEQ_W'(1);
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_exp_seq <= n_exp_seq;
                r_total   <= n_total;
            end
            if (o_pop && produce) begin
                r_out_valid <= 1'b1;
            end else if (o_ack.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && produce) begin
            r_ack_number  <= n_ack_number;
            r_end_ack     <= n_end_ack;
            r_accepted    <= n_accepted;
            r_total_bytes <= n_total_bytes;
        end
    end

    assign o_ack.valid       = r_out_valid;
    assign o_ack.ack_number  = r_ack_number;
    assign o_ack.end_ack     = r_end_ack;
    assign o_ack.accepted    = r_accepted;
    assign o_ack.total_bytes = r_total_bytes;

endmodule

// File: sv/gbn_receiver_with_checksum.sv
// go-back-n receiver with ones'-complement checksum
// i_pkt takes one 16-bit packet word per item; last_word marks the final word,
// and seq_number, end_flag and payload_length are sampled with it
// o_ack gives at most one acknowledgement per packet, only after its last word
// i_cfg_we/i_cfg_index/i_cfg_data write source address, destination address and
// pseudo-header length; a write during a packet takes effect from the next one
// throughput: one word per cycle while the queue is not full, set by the
// single checksum add in the front; a packet's descriptor is registered in
// the queue, then its ack in the output register in the back
// finished packets wait in a small queue; the back keeps expected sequence and
// byte count, so a stalled o_ack only stops i_pkt once that queue is full
// (QUEUE_DEPTH packets waiting); words of a packet keep flowing until then
// reset: expected sequence 1, byte count 0, addresses 0, length 2068, no ack
// pending; items may be sent the cycle after reset is released
module gbn_receiver_with_checksum import gbnrx_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    gbnrx_in_if.sink             i_pkt,
    gbnrx_out_if.source          o_ack
);

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_valid;
    t_pkt_desc push_desc;
    t_pkt_desc head_desc;

    gbnrx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pkt       (i_pkt),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_desc      (push_desc)
    );

    gbnrx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (head_desc)
    );

    gbnrx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_desc    (head_desc),
        .o_pop     (q_pop),
        .o_ack     (o_ack)
    );

endmodule

// File: sv/gbnrx_checker.sv
module gbnrx_checker import gbnrx_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [SEQ_W-1:0] i_ack_number,
    input logic [CNT_W-1:0] i_total_bytes
);

    // no ack pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("ack valid after reset");

    // input side only backs up behind a stalled ack
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !i_in_ready |-> $past(i_out_valid && !i_out_ready))
        else $error("input stalled without a stalled ack");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("ack dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_ack_number) && $stable(i_total_bytes))
        else $error("ack payload changed while stalled");

endmodule

bind gbn_receiver_with_checksum gbnrx_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_pkt.ready),
    .i_out_valid   (o_ack.valid),
    .i_out_ready   (o_ack.ready),
    .i_ack_number  (o_ack.ack_number),
    .i_total_bytes (o_ack.total_bytes)
);
